>>> design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Request and response payloads, request and status codes, cell controls.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 6;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic                      req_type;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] removed_value;
        logic [OCC_W-1:0]          occupancy;
    } t_rsp;

    // shift commands broadcast to every cell
    typedef struct packed {
        logic do_insert;
        logic do_remove;
    } t_cell_ctl;

endpackage

>>> design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one value, compares it with the incoming one and shifts with its
// neighbors on insert (toward the tail) and remove (toward the head).
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                               i_clk,
    input  spq_pkg::t_cell_ctl                 i_ctl,
    input  logic signed [spq_pkg::VALUE_W-1:0] i_value,
    input  logic                               i_occupied,
    input  logic                               i_prev_keep,
    input  logic signed [spq_pkg::VALUE_W-1:0] i_prev_data,
    input  logic signed [spq_pkg::VALUE_W-1:0] i_next_data,
    output logic                               o_keep,
    output logic signed [spq_pkg::VALUE_W-1:0] o_data
);

    logic signed [spq_pkg::VALUE_W-1:0] r_data;

    // stored value stays put when its slot is occupied and it is greater than or equal to the new one
    assign o_keep = i_occupied && !(i_value > r_data);
    assign o_data = r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.do_insert && !o_keep) begin
            r_data <= i_prev_keep ? i_value : i_prev_data;
        end else if (i_ctl.do_remove) begin
            r_data <= i_next_data;
        end
    end

endmodule

>>> design/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue of signed values
// A row of compare-and-shift cells keeps the values sorted largest first.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  request | in        | i_req_valid/o_req_stall | i_req (t_req)
//  response| out       | o_rsp_valid/i_rsp_stall | o_rsp (t_rsp)
//
//  one request per cycle while not stalled; its response is registered and
//  appears the next cycle. every cell compares against the new value in parallel
//  and shifts with its neighbor in the same cycle, so no request waits on another.
//  reset clears the count and the response valid; slot contents are
//  not cleared. the request side stalls only while a held response is stalled.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  spq_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output spq_pkg::t_rsp o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = spq_pkg::OCC_W;

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_rsp_valid;
    spq_pkg::t_rsp       r_rsp;
    spq_pkg::t_rsp       n_rsp;
    spq_pkg::t_cell_ctl  ctl;
    logic                accept;
    logic                full;
    logic                empty;
    logic [CW+OW-1:0]    occ_ext;

    logic                                    keep   [DEPTH];
    logic signed [spq_pkg::VALUE_W-1:0]      data   [DEPTH];

    assign o_req_stall = r_rsp_valid && i_rsp_stall;
    assign accept      = i_req_valid && !o_req_stall;
    assign full        = (r_count == CW'(DEPTH));
    assign empty       = (r_count == '0);

    always_comb begin
        ctl.do_insert = accept && (i_req.req_type == spq_pkg::REQ_INSERT) && !full;
        ctl.do_remove = accept && (i_req.req_type == spq_pkg::REQ_REMOVE) && !empty;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                               prev_keep;
        logic signed [spq_pkg::VALUE_W-1:0] prev_data;
        logic signed [spq_pkg::VALUE_W-1:0] next_data;

        if (g == 0) begin : g_head
            assign prev_keep = 1'b1;
            assign prev_data = i_req.value;
        end else begin : g_body
            assign prev_keep = keep[g-1];
            assign prev_data = data[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign next_data = '0;
        end else begin : g_inner
            assign next_data = data[g+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_value     (i_req.value),
            .i_occupied  (CW'(g) < r_count),
            .i_prev_keep (prev_keep),
            .i_prev_data (prev_data),
            .i_next_data (next_data),
            .o_keep      (keep[g]),
            .o_data      (data[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (ctl.do_insert) begin
            n_count = r_count + CW'(1);
        end else if (ctl.do_remove) begin
            n_count = r_count - CW'(1);
        end
    end

    assign occ_ext = (CW + OW)'(n_count);

    always_comb begin
        n_rsp.status        = spq_pkg::ST_OK;
        n_rsp.removed_value = '0;
        n_rsp.occupancy     = occ_ext[OW-1:0];
        if (i_req.req_type == spq_pkg::REQ_INSERT) begin
            if (full) begin
                n_rsp.status = spq_pkg::ST_OVERFLOW;
            end
        end else begin
            if (empty) begin
                n_rsp.status = spq_pkg::ST_UNDERFLOW;
            end else begin
                n_rsp.removed_value = data[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_rsp_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // response payload, loaded with each accepted transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule
